// ===== sv/rsrw_pkg.sv =====
package rsrw_pkg;

   localparam int unsigned RING_DEPTH = 16384;
   localparam int unsigned SLOT_W     = 14;
   localparam int unsigned MAX_OUT    = 8;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned STEP_W     = 21;
   localparam int unsigned GAIN_W     = 9;
   localparam int unsigned ACC_W      = 48;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned PLAY_W     = 31;
   localparam int unsigned VALUE_W    = 24;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 21;

   localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(8192);
   localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(1048576);
   localparam logic [STEP_W-1:0] STEP_INIT = STEP_W'(65536);
   localparam logic [GAIN_W-1:0] GAIN_MAX  = GAIN_W'(256);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE        = 3'd0,
      CSR_STEREO_SOURCE = 3'd1,
      CSR_WIDE_SAMPLES  = 3'd2,
      CSR_RATE_STEP     = 3'd3,
      CSR_GAIN          = 3'd4
   } csr_index_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   typedef struct packed {
      logic              enable;
      logic              stereo_source;
      logic              wide_samples;
      logic [STEP_W-1:0] rate_step;
      logic [GAIN_W-1:0] gain;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        stream_id;
      logic              block_start;
      logic [PLAY_W-1:0] play_position;
      logic [15:0]       left_raw;
      logic [15:0]       right_raw;
   } req_type;

   typedef struct packed {
      logic [1:0]                stream_id;
      logic                      block_start;
      logic [PLAY_W-1:0]         play_position;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;
   } job_type;

   typedef struct packed {
      logic [SLOT_W-1:0]         ring_slot;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;
      logic [1:0]                out_stream;
      logic                      overrun;
      logic                      last_of_run;
   } rsp_type;

endpackage

// ===== sv/rsrw_fifo.sv =====
module rsrw_fifo #(
   parameter type T     = logic,
   parameter int  DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_data,
   output logic full,
   input  logic pop,
   output T     pop_data,
   output logic empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   T                 mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/rsrw_front.sv =====
module rsrw_front #(
   parameter int RAW_STREAMS = 4
) (
   input  rsrw_pkg::cfg_type cfg,
   input  logic              req_push,
   input  rsrw_pkg::req_type req_data,
   input  logic              job_full,
   output logic              job_push,
   output rsrw_pkg::job_type job
);
   import rsrw_pkg::*;

   logic               keep;
   logic               mono;
   logic [GAIN_W-1:0]  gain_sat;
   logic signed [16:0] left_s, right_s;
   logic signed [26:0] left_p, right_p;

   function automatic logic signed [16:0] decode(input logic [15:0] raw,
                                                 input logic wide,
                                                 input logic is_mono);
      logic signed [16:0] v;
      begin
         if (wide) begin
            v = 17'(signed'(raw));
         end else if (is_mono) begin
            v = $signed({9'b0, raw[7:0]}) - 17'sd128;
         end else begin
            v = 17'(signed'(raw[7:0]));
         end
         return v;
      end
   endfunction

   assign keep = cfg.enable && ({30'b0, req_data.stream_id} < 32'(RAW_STREAMS));
   assign mono = !cfg.stereo_source;
   assign job_push = req_push && !job_full && keep;

   always_comb begin
      gain_sat = (cfg.gain > GAIN_MAX) ? GAIN_MAX : cfg.gain;
      left_s   = decode(req_data.left_raw, cfg.wide_samples, mono);
      right_s  = mono ? left_s : decode(req_data.right_raw, cfg.wide_samples, mono);
      left_p   = 27'(left_s) * 27'($signed({1'b0, gain_sat}));
      right_p  = 27'(right_s) * 27'($signed({1'b0, gain_sat}));

      job.stream_id     = req_data.stream_id;
      job.block_start   = req_data.block_start;
      job.play_position = req_data.play_position;
      // 8-bit data carries an extra factor of 256
      if (cfg.wide_samples) begin
         job.left_value  = left_p[VALUE_W-1:0];
         job.right_value = right_p[VALUE_W-1:0];
      end else begin
         job.left_value  = {left_p[VALUE_W-9:0], 8'b0};
         job.right_value = {right_p[VALUE_W-9:0], 8'b0};
      end
   end

endmodule

// ===== sv/rsrw_back.sv =====
module rsrw_back #(
   parameter int RAW_STREAMS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  rsrw_pkg::cfg_type cfg,
   input  logic              job_empty,
   input  rsrw_pkg::job_type job,
   output logic              job_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output rsrw_pkg::rsp_type rsp
);
   import rsrw_pkg::*;

   // stream_id is two bits wide, so at most four rings are addressable
   localparam int NSTREAM = (RAW_STREAMS < 4) ? RAW_STREAMS : 4;
   localparam int SID_W   = (NSTREAM > 1) ? $clog2(NSTREAM) : 1;

   back_state_type    state_ff, state_in;
   logic [POS_W-1:0]  wp_ff [NSTREAM];
   logic [POS_W-1:0]  wp_in;
   logic              wp_we;
   logic [ACC_W-1:0]  acc_ff, acc_in, acc_next;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PLAY_W-1:0] play_ff, play_in;
   logic [SID_W-1:0]  sid;
   logic [POS_W-1:0]  wp_cur, wp_inc;
   logic [STEP_W-1:0] step;
   logic              hit, next_hit;

   assign sid    = job.stream_id[SID_W-1:0];
   assign wp_cur = wp_ff[sid];
   assign wp_inc = wp_cur + 1'b1;

   always_comb begin
      if (cfg.rate_step < STEP_MIN) begin
         step = STEP_MIN;
      end else if (cfg.rate_step > STEP_MAX) begin
         step = STEP_MAX;
      end else begin
         step = cfg.rate_step;
      end
   end

   assign acc_next = acc_ff + ACC_W'(step);
   assign hit      = (acc_ff[ACC_W-1:16] == idx_ff) && (cnt_ff != CNT_W'(MAX_OUT));
   assign next_hit = (acc_next[ACC_W-1:16] == idx_ff) &&
                     (cnt_ff + 1'b1 != CNT_W'(MAX_OUT));

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      play_in  = play_ff;
      wp_in    = wp_inc;
      wp_we    = 1'b0;
      job_pop  = 1'b0;
      rsp_push = 1'b0;

      rsp.ring_slot   = wp_cur[SLOT_W-1:0];
      rsp.left_value  = job.left_value;
      rsp.right_value = job.right_value;
      rsp.out_stream  = job.stream_id;
      rsp.overrun     = {1'b0, wp_inc} > ({2'b0, play_ff} + 33'(RING_DEPTH));
      rsp.last_of_run = !next_hit;

      unique case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) begin
               cnt_in   = '0;
               state_in = BACK_RUN;
               if (job.block_start) begin
                  play_in = job.play_position;
                  acc_in  = '0;
                  idx_in  = '0;
                  wp_in   = {1'b0, job.play_position};
                  wp_we   = (wp_cur < {1'b0, job.play_position});
               end
            end
         end
         BACK_RUN: begin
            if (hit) begin
               if (!rsp_full) begin
                  rsp_push = 1'b1;
                  wp_we    = 1'b1;
                  acc_in   = acc_next;
                  cnt_in   = cnt_ff + 1'b1;
                  if (!next_hit) begin
                     idx_in   = idx_ff + 1'b1;
                     job_pop  = 1'b1;
                     state_in = BACK_IDLE;
                  end
               end
            end else begin
               // frame skipped by the step, or run cap reached
               idx_in   = idx_ff + 1'b1;
               job_pop  = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         acc_ff   <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         play_ff  <= '0;
         for (int k = 0; k < NSTREAM; k++) begin
            wp_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         play_ff  <= play_in;
         if (wp_we) begin
            wp_ff[sid] <= wp_in;
         end
      end
   end

`ifndef SYNTH
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_OUT))
      else $error("run count above cap");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   a_pop_in_run: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == BACK_RUN && !job_empty))
      else $error("job popped outside run");

   a_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_IDLE && !job_empty) |=> (state_ff == BACK_RUN && cnt_ff == '0))
      else $error("pending job not started");
`endif

endmodule

// ===== sv/raw_sample_resample_ring_writer.sv =====
// Nearest-neighbor resampler feeding per-stream audio rings.
// Input queue port: drive req_data and req_push; a beat is taken when req_full
// is low. Frames are dropped when enable is clear or stream_id is out of range.
// Result queue port: while rsp_empty is low, rsp_data holds the oldest pair
// (ring slot, scaled left/right, stream, overrun, last_of_run); rsp_pop takes it.
// Config port: csr_valid/csr_ready with csr_index and csr_wdata; csr_ready is
// always high. Write registers only while the block is idle.
// Path: an accepted frame enters the job queue, is loaded by the sequencer in its
// idle state, and gives its results, if any, from the run state to the result queue.
// Throughput: the back-end sequencer gives one result per cycle while the result
// queue has room, after a load step per frame; a frame gives 0 to 8 results.
// A two-entry job queue sits between the format/gain front end and the sequencer.
// Stall: when the result queue fills the sequencer holds; the job queue then
// fills and req_full rises. Nothing is lost.
// Reset clears write positions, phase, index, queues and registers to defaults.
module raw_sample_resample_ring_writer #(
   parameter int RAW_STREAMS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  rsrw_pkg::req_type                    req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output rsrw_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rsrw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rsrw_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rsrw_pkg::*;

   cfg_type cfg_ff;
   logic    job_push, job_full, job_empty, job_pop;
   job_type job_in_data, job_head;
   logic    out_push, out_full;
   rsp_type out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.stereo_source <= 1'b1;
         cfg_ff.wide_samples  <= 1'b1;
         cfg_ff.rate_step     <= STEP_INIT;
         cfg_ff.gain          <= GAIN_MAX;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:        cfg_ff.enable        <= csr_wdata[0];
            CSR_STEREO_SOURCE: cfg_ff.stereo_source <= csr_wdata[0];
            CSR_WIDE_SAMPLES:  cfg_ff.wide_samples  <= csr_wdata[0];
            CSR_RATE_STEP:     cfg_ff.rate_step     <= csr_wdata[STEP_W-1:0];
            CSR_GAIN:          cfg_ff.gain          <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_full = job_full;

   rsrw_front #(
      .RAW_STREAMS(RAW_STREAMS)
   ) u_front (
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_data (req_data),
      .job_full (job_full),
      .job_push (job_push),
      .job      (job_in_data)
   );

   rsrw_fifo #(
      .T     (job_type),
      .DEPTH (2)
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_head),
      .empty     (job_empty)
   );

   rsrw_back #(
      .RAW_STREAMS(RAW_STREAMS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .rsp_full  (out_full),
      .rsp_push  (out_push),
      .rsp       (out_data)
   );

   rsrw_fifo #(
      .T     (rsp_type),
      .DEPTH (4)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
